[rtl/core/hfog_pkg.sv]
// Shared types and constants of the Huber objective and gradient engine.
package hfog_pkg;

    localparam int unsigned DELTA_W = 31;
    localparam int unsigned DIMS_W  = 5;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned OBJ_W   = 63;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 136;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic [DELTA_W-1:0] DELTA_RESET = 31'd65536;
    localparam logic [DIMS_W-1:0]  DIMS_RESET  = 5'd16;
    localparam logic [ACC_W-1:0]   OBJ_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    // Register index, taken from paddr[2].
    localparam logic REG_DELTA = 1'b0;
    localparam logic REG_DIMS  = 1'b1;

    localparam logic MODE_CENTER = 1'b0;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_DIFF  = 15'b000000000000010,
        S_SQ    = 15'b000000000000100,
        S_SQACC = 15'b000000000001000,
        S_ROW   = 15'b000000000010000,
        S_SQRT  = 15'b000000000100000,
        S_LOSS0 = 15'b000000001000000,
        S_LOSS1 = 15'b000000010000000,
        S_GRD   = 15'b000000100000000,
        S_GMUL  = 15'b000001000000000,
        S_GDIV  = 15'b000010000000000,
        S_GWR   = 15'b000100000000000,
        S_ERD   = 15'b001000000000000,
        S_ELD   = 15'b010000000000000,
        S_EOUT  = 15'b100000000000000
    } t_state;

endpackage

[rtl/core/huber_frechet_objective_gradient.sv]
// Sequence: a center coordinate is stored in idle; a point coordinate in range passes DIFF, SQ,
// SQACC and ROW. A row end adds the serial square root, LOSS0, LOSS1 and per coordinate GRD, GMUL,
// GWR, with the bit-serial 64-step divider (GDIV) before GWR outside delta; results pass ERD, ELD, EOUT.
// Throughput: one item at a time; the shared memories and the serial sqrt/divide set it.
// Reset: synchronous, active low; registers return to delta 1.0, 16 dimensions, and
// cleared accumulators (valid bits stand in for the gradient and row-difference memories).
module huber_frechet_objective_gradient #(
    parameter int MAX_DIMS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: coord_index [3:0], coord_value [35:4], zero fill [39:36]
    input  logic [hfog_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: mode
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: grad_component [63:0], objective [126:64], component_index [130:127], zeros
    output logic [hfog_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: saturated
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hfog_pkg::APB_AW-1:0]         paddr,
    input  logic [hfog_pkg::APB_DW-1:0]         pwdata,
    output logic [hfog_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import hfog_pkg::*;

    localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    // Configuration registers.
    logic [DELTA_W-1:0] r_delta;
    logic [DIMS_W-1:0]  r_dims;

    // Control and accumulator state.
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx;
    logic signed [VAL_W-1:0] r_val;
    logic                r_lastp;
    logic [63:0]         r_sqsum;
    logic [OBJ_W-1:0]    r_obj;
    logic                r_sat;
    logic [MAX_DIMS-1:0] r_dvalid;
    logic [MAX_DIMS-1:0] r_gvalid;
    logic [AW-1:0]       r_k;
    logic [5:0]          r_cnt;
    logic                r_inner;

    // Datapath registers.
    logic signed [VAL_W-1:0] r_center_rd;
    logic signed [32:0]  r_diff_rd;
    logic signed [63:0]  r_grad_rd;
    logic [31:0]         r_mag;
    logic [63:0]         r_sq;
    logic [63:0]         r_sx;
    logic [34:0]         r_srem;
    logic [31:0]         r_root;
    logic [62:0]         r_p1;
    logic [61:0]         r_p2;
    logic                r_gneg;
    logic signed [63:0]  r_gacc;
    logic signed [63:0]  r_t;
    logic [63:0]         r_dvd;
    logic [32:0]         r_drem;
    logic [63:0]         r_quo;
    logic signed [63:0]  r_o_grad;
    logic [IDX_W-1:0]    r_o_idx;
    logic                r_o_last;

    // Memories: center coordinates, row differences and gradient accumulators.
    logic signed [VAL_W-1:0] center_mem [MAX_DIMS];
    logic signed [32:0]      diff_mem   [MAX_DIMS];
    logic signed [63:0]      grad_mem   [MAX_DIMS];

    // Input field unpacking.
    logic [IDX_W-1:0]        in_idx;
    logic signed [VAL_W-1:0] in_val;
    logic                    in_acc;
    assign in_idx = s_axis_tdata[3:0];
    assign in_val = s_axis_tdata[35:4];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Effective dimension count, clamped to 1..MAX_DIMS.
    logic [7:0] dims8, n8, in_idx8, idx8, k8;
    assign dims8   = {3'b0, r_dims};
    assign n8      = (dims8 == 8'd0) ? 8'd1 :
                     (dims8 > 8'(MAX_DIMS)) ? 8'(MAX_DIMS) : dims8;
    assign in_idx8 = {4'b0, in_idx};
    assign idx8    = {4'b0, r_idx};
    assign k8      = 8'(r_k);

    logic [AW-1:0] in_addr, idx_addr;
    assign in_addr  = in_idx8[AW-1:0];
    assign idx_addr = idx8[AW-1:0];

    logic row_end, k_last;
    assign row_end = (idx8 == n8 - 8'd1) || r_lastp;
    assign k_last  = (k8 == n8 - 8'd1);

    // Difference to the center and its magnitude.
    logic signed [32:0] diff_c;
    logic [32:0]        diff_abs;
    assign diff_c   = 33'(r_val) - 33'(r_center_rd);
    assign diff_abs = diff_c[32] ? -diff_c : diff_c;

    // Square sum, saturating.
    logic [64:0] sq_sum_c;
    assign sq_sum_c = {1'b0, r_sqsum} + {1'b0, r_sq};

    // One square-root digit per cycle.
    logic [34:0] sq_rem2, sq_trial;
    logic        sq_ge;
    assign sq_rem2  = {r_srem[32:0], r_sx[63:62]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);

    // Loss of the row and its saturating add into the objective.
    logic [63:0] loss_c, obj_sum_c;
    assign loss_c    = r_inner ? {17'b0, r_sqsum[63:17]}
                               : 64'(({1'b0, r_p1} - {2'b0, r_p2[61:1]}) >> 16);
    assign obj_sum_c = {1'b0, r_obj} + loss_c;

    // Gradient operands, masked by the valid bits.
    logic signed [32:0] gd_c;
    logic [32:0]        gmag_c;
    assign gd_c   = r_dvalid[r_k] ? r_diff_rd : 33'sd0;
    assign gmag_c = gd_c[32] ? -gd_c : gd_c;

    // One quotient bit per cycle: rem stays below the root, so 33 bits suffice.
    logic [32:0] dv_rem2;
    logic        dv_ge;
    assign dv_rem2 = {r_drem[31:0], r_dvd[63]};
    assign dv_ge   = (dv_rem2 >= {1'b0, r_root});

    logic signed [64:0] g_sum_c;
    logic signed [63:0] g_new_c;
    assign g_sum_c = {r_gacc[63], r_gacc} + {r_t[63], r_t};
    always_comb begin
        if (g_sum_c[64] != g_sum_c[63]) begin
            g_new_c = g_sum_c[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            g_new_c = g_sum_c[63:0];
        end
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Center memory: written by center transfers, read when a point coordinate enters.
    always_ff @(posedge i_clk) begin
        if (in_acc && s_axis_tuser == MODE_CENTER && in_idx8 < 8'(MAX_DIMS)) begin
            center_mem[in_addr] <= in_val;
        end
        if (in_acc) begin
            r_center_rd <= center_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIFF) begin
            diff_mem[idx_addr] <= diff_c;
        end
        if (r_state == S_GRD) begin
            r_diff_rd <= diff_mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_GWR) begin
            grad_mem[r_k] <= g_new_c;
        end
        if (r_state == S_GRD || r_state == S_ERD) begin
            r_grad_rd <= grad_mem[r_k];
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && s_axis_tuser != MODE_CENTER) begin
                    n_state = (in_idx8 < n8) ? S_DIFF : S_ROW;
                end
            end
            S_DIFF:  n_state = S_SQ;
            S_SQ:    n_state = S_SQACC;
            S_SQACC: n_state = S_ROW;
            S_ROW:   n_state = row_end ? S_SQRT : S_IDLE;
            S_SQRT:  n_state = (r_cnt == 6'd31) ? S_LOSS0 : S_SQRT;
            S_LOSS0: n_state = S_LOSS1;
            S_LOSS1: n_state = S_GRD;
            S_GRD:   n_state = S_GMUL;
            S_GMUL:  n_state = r_inner ? S_GWR : S_GDIV;
            S_GDIV:  n_state = (r_cnt == 6'd63) ? S_GWR : S_GDIV;
            S_GWR: begin
                if (!k_last) begin
                    n_state = S_GRD;
                end else begin
                    n_state = r_lastp ? S_ERD : S_IDLE;
                end
            end
            S_ERD:   n_state = S_ELD;
            S_ELD:   n_state = S_EOUT;
            S_EOUT: begin
                if (m_axis_tready) begin
                    n_state = k_last ? S_IDLE : S_ERD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_delta  <= DELTA_RESET;
            r_dims   <= DIMS_RESET;
            r_sqsum  <= '0;
            r_obj    <= '0;
            r_sat    <= 1'b0;
            r_dvalid <= '0;
            r_gvalid <= '0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_lastp  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                if (paddr[2] == REG_DELTA) begin
                    r_delta <= pwdata[DELTA_W-1:0];
                end else begin
                    r_dims <= pwdata[DIMS_W-1:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_lastp <= s_axis_tlast;
                    end
                end
                S_DIFF: begin
                    r_dvalid[idx_addr] <= 1'b1;
                end
                S_SQACC: begin
                    if (sq_sum_c[64]) begin
                        r_sqsum <= {64{1'b1}};
                        r_sat   <= 1'b1;
                    end else begin
                        r_sqsum <= sq_sum_c[63:0];
                    end
                end
                S_ROW: begin
                    r_cnt <= '0;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 6'd1;
                end
                S_LOSS1: begin
                    if (obj_sum_c > OBJ_MAX) begin
                        r_obj <= OBJ_MAX[OBJ_W-1:0];
                        r_sat <= 1'b1;
                    end else begin
                        r_obj <= obj_sum_c[OBJ_W-1:0];
                    end
                    r_k <= '0;
                end
                S_GMUL: begin
                    r_cnt <= '0;
                end
                S_GDIV: begin
                    r_cnt <= r_cnt + 6'd1;
                end
                S_GWR: begin
                    r_gvalid[r_k] <= 1'b1;
                    if (g_sum_c[64] != g_sum_c[63]) begin
                        r_sat <= 1'b1;
                    end
                    if (!k_last) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        // Row done: row differences and square sum start over.
                        r_dvalid <= '0;
                        r_sqsum  <= '0;
                        r_k      <= '0;
                    end
                end
                S_EOUT: begin
                    if (m_axis_tready) begin
                        if (k_last) begin
                            r_gvalid <= '0;
                            r_obj    <= '0;
                            r_sat    <= 1'b0;
                            r_k      <= '0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_idx <= in_idx;
                    r_val <= in_val;
                end
            end
            S_DIFF: begin
                r_mag <= diff_abs[31:0];
            end
            S_SQ: begin
                r_sq <= r_mag * r_mag;
            end
            S_ROW: begin
                r_sx   <= r_sqsum;
                r_srem <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_srem <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
                r_root <= {r_root[30:0], sq_ge};
                r_sx   <= {r_sx[61:0], 2'b00};
            end
            S_LOSS0: begin
                r_inner <= ({1'b0, r_root} <= {2'b0, r_delta});
                r_p1    <= r_delta * r_root;
                r_p2    <= r_delta * r_delta;
            end
            S_GMUL: begin
                r_gacc <= r_gvalid[r_k] ? r_grad_rd : 64'sd0;
                r_gneg <= gd_c[32];
                r_t    <= -(64'(gd_c));
                r_dvd  <= {1'b0, 63'(gmag_c[31:0]) * 63'(r_delta)};
                r_drem <= '0;
                r_quo  <= '0;
            end
            S_GDIV: begin
                r_drem <= dv_ge ? (dv_rem2 - {1'b0, r_root}) : dv_rem2;
                r_dvd  <= {r_dvd[62:0], 1'b0};
                r_quo  <= {r_quo[62:0], dv_ge};
                if (r_cnt == 6'd63) begin
                    r_t <= r_gneg ? $signed({r_quo[62:0], dv_ge})
                                  : -$signed({r_quo[62:0], dv_ge});
                end
            end
            S_ELD: begin
                r_o_grad <= r_gvalid[r_k] ? r_grad_rd : 64'sd0;
                r_o_idx  <= k8[IDX_W-1:0];
                r_o_last <= k_last;
            end
            default: begin
            end
        endcase
    end

    // Ports.
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_EOUT);
    assign m_axis_tdata  = {5'b0, r_o_idx, r_obj, r_o_grad};
    assign m_axis_tuser  = r_sat;
    assign m_axis_tlast  = r_o_last;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_DIMS) ? {27'b0, r_dims} : {1'b0, r_delta};

endmodule

[rtl/core/hfog_checker.sv]
// Port-level checker for the Huber objective and gradient engine, with its bind.
module hfog_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [hfog_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);
    import hfog_pkg::*;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No new input is taken while results are being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready during result delivery");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // After the last result of a run the block returns to taking input.
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("block did not return to idle after the run");

endmodule

bind huber_frechet_objective_gradient hfog_checker u_hfog_checker (.*);
